// ===== rtl/core/gaussian_weighted_table_mean_core_assert.svh =====
// Assertion macros for the gaussian weighted table mean core.
`ifndef GAUSSIAN_WEIGHTED_TABLE_MEAN_CORE_ASSERT_SVH
`define GAUSSIAN_WEIGHTED_TABLE_MEAN_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define GWTM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gwtm: implication check failed");
`define GWTM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gwtm: next-cycle check failed");
`else
`define GWTM_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define GWTM_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/core/gwtm_pkg.sv =====
// Shared types and constants of the gaussian weighted table mean core.
package gwtm_pkg;

    localparam int BINS         = 1024;
    localparam int IDX_W        = $clog2(BINS);
    localparam int CNT_W        = $clog2(BINS + 1);
    localparam int ADDR_W       = 5;
    localparam int HORNER_TERMS = 10;
    localparam int SQUARINGS    = 4;
    localparam int EXP_LIMIT_SH = 4;
    localparam int XDIV_BITS    = 20;
    localparam int MUL_W        = 33;
    localparam int PROD_W       = 2 * MUL_W;
    localparam int W_W          = 33 + IDX_W;
    localparam int WI_W         = 32 + 2 * IDX_W;
    localparam int QDIV_W       = (IDX_W + 16 > XDIV_BITS) ? IDX_W + 16 : XDIV_BITS;
    localparam int DIV_W        = (2 * IDX_W + 49 > 58) ? 2 * IDX_W + 49 : 58;
    localparam int DCNT_W       = $clog2(QDIV_W);
    localparam int MSUM_W       = ((QDIV_W > 24) ? QDIV_W : 24) + 2;

    localparam logic [31:0] ONE_Q31 = 32'h8000_0000;

    localparam logic [32:0] RECIP_TAB [HORNER_TERMS + 1] = '{
        33'd0,
        33'd4294967296,
        33'd2147483648,
        33'd1431655765,
        33'd1073741824,
        33'd858993459,
        33'd715827882,
        33'd613566756,
        33'd536870912,
        33'd477218588,
        33'd429496729
    };

    typedef enum logic [2:0] {
        REG_GRID_START  = 3'd0,
        REG_GRID_STEP   = 3'd1,
        REG_BINS_IN_USE = 3'd2,
        REG_OBS_SCATTER = 3'd3,
        REG_INT_SCATTER = 3'd4
    } reg_addr_t;

    typedef enum logic {
        ACT_LOAD  = 1'b0,
        ACT_QUERY = 1'b1
    } action_t;

    typedef struct packed {
        logic               action;
        logic [9:0]         bin_index;
        logic signed [23:0] bin_stellar_mass;
        logic [31:0]        bin_density;
        logic signed [23:0] query_mass;
    } in_t;

    typedef struct packed {
        logic signed [23:0] mean_halo_mass;
        logic               invalid;
    } out_t;

endpackage

// ===== rtl/core/gaussian_weighted_table_mean_core.sv =====
// Gaussian kernel weighted mean over a loaded mass table, APB configured.
// A load is written when accepted and busy stays low; one query runs at a time. A query
// runs setup, then per bin a read and a kernel limit check, with exponent and weighting
// only for bins within the limit, then final division and scaling; done then pulses for
// one cycle. The per-bin cost is set by the shared 33x33 multiplier and the radix-2
// divider. rst_n clears control and restores register defaults; tables are kept.
`include "gaussian_weighted_table_mean_core_assert.svh"

module gaussian_weighted_table_mean_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  gwtm_pkg::in_t               cmd,
    output logic                        done,
    output gwtm_pkg::out_t              result,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [gwtm_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    typedef enum logic [21:0] {
        ST_IDLE   = 22'h000001,
        ST_VAR_A  = 22'h000002,
        ST_VAR_B  = 22'h000004,
        ST_VAR_C  = 22'h000008,
        ST_VAR_D  = 22'h000010,
        ST_RD     = 22'h000020,
        ST_DIFF   = 22'h000040,
        ST_CMP    = 22'h000080,
        ST_XDIV   = 22'h000100,
        ST_H_MUL  = 22'h000200,
        ST_H_REC  = 22'h000400,
        ST_H_FIX  = 22'h000800,
        ST_SQ_MUL = 22'h001000,
        ST_SQ_RES = 22'h002000,
        ST_DW_MUL = 22'h004000,
        ST_DW_IDX = 22'h008000,
        ST_ACC    = 22'h010000,
        ST_NEXT   = 22'h020000,
        ST_FIN    = 22'h040000,
        ST_FDIV   = 22'h080000,
        ST_FMUL   = 22'h100000,
        ST_FADD   = 22'h200000
    } state_t;

    localparam int IW = gwtm_pkg::IDX_W;

    // configuration
    logic signed [23:0] cfg_start_reg, cfg_start_next;
    logic [15:0]        cfg_step_reg, cfg_step_next;
    logic [10:0]        cfg_bins_reg, cfg_bins_next;
    logic [17:0]        cfg_obs_reg, cfg_obs_next;
    logic [17:0]        cfg_int_reg, cfg_int_next;
    logic               cfg_we;

    // control
    state_t                        state_reg, state_next;
    logic [IW-1:0]                 idx_reg, idx_next;
    logic [gwtm_pkg::DCNT_W-1:0]   div_cnt_reg, div_cnt_next;
    logic [3:0]                    k_reg, k_next;
    logic [1:0]                    sq_cnt_reg, sq_cnt_next;
    logic                          done_reg, done_next;

    // datapath
    logic signed [23:0]            q_reg, q_next;
    logic [36:0]                   var_reg, var_next;
    logic [gwtm_pkg::DIV_W-1:0]    div_n_reg, div_n_next, div_d_reg, div_d_next;
    logic [gwtm_pkg::QDIV_W-1:0]   div_q_reg, div_q_next;
    logic [30:0]                   t_reg, t_next;
    logic [31:0]                   r_reg, r_next;
    logic [30:0]                   pd_reg, pd_next;
    logic [gwtm_pkg::W_W-1:0]      w_reg, w_next;
    logic [gwtm_pkg::WI_W-1:0]     wi_reg, wi_next;
    gwtm_pkg::out_t                res_reg, res_next;
    logic [gwtm_pkg::PROD_W-1:0]   mul_prod_reg;
    logic [gwtm_pkg::MUL_W-1:0]    mul_a, mul_b;

    // tables
    logic signed [23:0] sm_mem [gwtm_pkg::BINS];
    logic [31:0]        dens_mem [gwtm_pkg::BINS];
    logic signed [23:0] sm_rd_reg;
    logic [31:0]        dens_rd_reg;
    logic               load_we;

    logic                          accept;
    logic [gwtm_pkg::CNT_W-1:0]    n_bins;
    logic [37:0]                   two_var;
    logic signed [24:0]            dm;
    logic [24:0]                   dm_abs;
    logic [48:0]                   dm2;
    logic                          div_ge;
    logic [gwtm_pkg::DIV_W-1:0]    div_n_step;
    logic [gwtm_pkg::QDIV_W-1:0]   div_q_step;
    logic [30:0]                   qe;
    logic [34:0]                   qe_k;
    logic [34:0]                   rem;
    logic [30:0]                   qc;
    logic [30:0]                   pd_now;
    logic [31:0]                   dw;
    logic signed [gwtm_pkg::MSUM_W-1:0] mean_sum;
    logic [gwtm_pkg::QDIV_W-1:0]   mean_off;

    assign pready  = 1'b1;
    assign busy    = (state_reg != ST_IDLE);
    assign accept  = start && !busy;
    assign load_we = accept && (cmd.action == gwtm_pkg::ACT_LOAD)
                     && (32'(cmd.bin_index) < 32'(gwtm_pkg::BINS));
    assign done    = done_reg;
    assign result  = res_reg;
    assign cfg_we  = psel && penable && pwrite;

    assign n_bins  = (32'(cfg_bins_reg) > 32'(gwtm_pkg::BINS))
                     ? gwtm_pkg::CNT_W'(gwtm_pkg::BINS) : gwtm_pkg::CNT_W'(cfg_bins_reg);
    assign two_var = {var_reg, 1'b0};
    assign dm      = {q_reg[23], q_reg} - {sm_rd_reg[23], sm_rd_reg};
    assign dm_abs  = dm[24] ? 25'(-dm) : 25'(dm);
    assign dm2     = mul_prod_reg[48:0];

    assign div_ge     = (div_n_reg >= div_d_reg);
    assign div_n_step = div_ge ? (div_n_reg - div_d_reg) : div_n_reg;
    assign div_q_step = {div_q_reg[gwtm_pkg::QDIV_W-2:0], div_ge};

    assign pd_now = mul_prod_reg[61:31];
    assign qe     = mul_prod_reg[62:32];
    assign qe_k   = 35'(qe) * 35'(k_reg);
    assign rem    = 35'(pd_reg) - qe_k;
    assign qc     = (rem >= 35'(k_reg)) ? (qe + 31'd1) : qe;
    assign dw     = mul_prod_reg[62:31];

    assign mean_off = mul_prod_reg[16 +: gwtm_pkg::QDIV_W];
    assign mean_sum = gwtm_pkg::MSUM_W'(cfg_start_reg) + $signed({2'b00, mean_off});

    // register file
    always_comb
    begin
        cfg_start_next = cfg_start_reg;
        cfg_step_next  = cfg_step_reg;
        cfg_bins_next  = cfg_bins_reg;
        cfg_obs_next   = cfg_obs_reg;
        cfg_int_next   = cfg_int_reg;
        if (cfg_we)
        begin
            case (paddr[4:2])
                gwtm_pkg::REG_GRID_START:  cfg_start_next = pwdata[23:0];
                gwtm_pkg::REG_GRID_STEP:   cfg_step_next  = pwdata[15:0];
                gwtm_pkg::REG_BINS_IN_USE: cfg_bins_next  = pwdata[10:0];
                gwtm_pkg::REG_OBS_SCATTER: cfg_obs_next   = pwdata[17:0];
                gwtm_pkg::REG_INT_SCATTER: cfg_int_next   = pwdata[17:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:2])
            gwtm_pkg::REG_GRID_START:  prdata = 32'(cfg_start_reg);
            gwtm_pkg::REG_GRID_STEP:   prdata = 32'(cfg_step_reg);
            gwtm_pkg::REG_BINS_IN_USE: prdata = 32'(cfg_bins_reg);
            gwtm_pkg::REG_OBS_SCATTER: prdata = 32'(cfg_obs_reg);
            gwtm_pkg::REG_INT_SCATTER: prdata = 32'(cfg_int_reg);
            default:                   prdata = 32'd0;
        endcase
    end

    // shared multiplier operands
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_VAR_A:
            begin
                mul_a = 33'(cfg_obs_reg);
                mul_b = 33'(cfg_obs_reg);
            end
            ST_VAR_B:
            begin
                mul_a = 33'(cfg_int_reg);
                mul_b = 33'(cfg_int_reg);
            end
            ST_DIFF:
            begin
                mul_a = 33'(dm_abs);
                mul_b = 33'(dm_abs);
            end
            ST_H_MUL:
            begin
                mul_a = 33'(t_reg);
                mul_b = 33'(r_reg);
            end
            ST_H_REC:
            begin
                mul_a = 33'(pd_now);
                mul_b = gwtm_pkg::RECIP_TAB[k_reg];
            end
            ST_SQ_MUL:
            begin
                mul_a = 33'(r_reg);
                mul_b = 33'(r_reg);
            end
            ST_DW_MUL:
            begin
                mul_a = 33'(dens_rd_reg);
                mul_b = 33'(r_reg);
            end
            ST_DW_IDX:
            begin
                mul_a = 33'(dw);
                mul_b = 33'(idx_reg);
            end
            ST_FMUL:
            begin
                mul_a = 33'(div_q_reg);
                mul_b = 33'(cfg_step_reg);
            end
            default: ;
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        div_cnt_next = div_cnt_reg;
        k_next       = k_reg;
        sq_cnt_next  = sq_cnt_reg;
        done_next    = 1'b0;
        q_next       = q_reg;
        var_next     = var_reg;
        div_n_next   = div_n_reg;
        div_d_next   = div_d_reg;
        div_q_next   = div_q_reg;
        t_next       = t_reg;
        r_next       = r_reg;
        pd_next      = pd_reg;
        w_next       = w_reg;
        wi_next      = wi_reg;
        res_next     = res_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (cmd.action == gwtm_pkg::ACT_QUERY))
                begin
                    q_next     = cmd.query_mass;
                    idx_next   = '0;
                    w_next     = '0;
                    wi_next    = '0;
                    state_next = ST_VAR_A;
                end
            end
            ST_VAR_A: state_next = ST_VAR_B;
            ST_VAR_B:
            begin
                var_next   = 37'(mul_prod_reg[35:0]);
                state_next = ST_VAR_C;
            end
            ST_VAR_C:
            begin
                var_next   = var_reg + 37'(mul_prod_reg[35:0]);
                state_next = ST_VAR_D;
            end
            ST_VAR_D:
            begin
                if (var_reg == '0)
                begin
                    res_next.mean_halo_mass = '0;
                    res_next.invalid        = 1'b1;
                    done_next               = 1'b1;
                    state_next              = ST_IDLE;
                end
                else if (n_bins == '0)
                    state_next = ST_FIN;
                else
                    state_next = ST_RD;
            end
            ST_RD:   state_next = ST_DIFF;
            ST_DIFF: state_next = ST_CMP;
            ST_CMP:
            begin
                if (dm2 >= (49'(two_var) << gwtm_pkg::EXP_LIMIT_SH))
                    state_next = ST_NEXT;
                else
                begin
                    div_n_next   = gwtm_pkg::DIV_W'(dm2) << 16;
                    div_d_next   = gwtm_pkg::DIV_W'(two_var) << (gwtm_pkg::XDIV_BITS - 1);
                    div_q_next   = '0;
                    div_cnt_next = gwtm_pkg::DCNT_W'(gwtm_pkg::XDIV_BITS - 1);
                    state_next   = ST_XDIV;
                end
            end
            ST_XDIV, ST_FDIV:
            begin
                div_n_next   = div_n_step;
                div_d_next   = div_d_reg >> 1;
                div_q_next   = div_q_step;
                div_cnt_next = div_cnt_reg - 1'b1;
                if (div_cnt_reg == '0)
                begin
                    if (state_reg == ST_XDIV)
                    begin
                        t_next     = {div_q_step[gwtm_pkg::XDIV_BITS-1:0], 11'b0};
                        r_next     = gwtm_pkg::ONE_Q31;
                        k_next     = 4'(gwtm_pkg::HORNER_TERMS);
                        state_next = ST_H_MUL;
                    end
                    else
                        state_next = ST_FMUL;
                end
            end
            ST_H_MUL: state_next = ST_H_REC;
            ST_H_REC:
            begin
                pd_next    = pd_now;
                state_next = ST_H_FIX;
            end
            ST_H_FIX:
            begin
                r_next = gwtm_pkg::ONE_Q31 - 32'(qc);
                if (k_reg == 4'd1)
                begin
                    sq_cnt_next = 2'(gwtm_pkg::SQUARINGS - 1);
                    state_next  = ST_SQ_MUL;
                end
                else
                begin
                    k_next     = k_reg - 4'd1;
                    state_next = ST_H_MUL;
                end
            end
            ST_SQ_MUL: state_next = ST_SQ_RES;
            ST_SQ_RES:
            begin
                r_next = mul_prod_reg[62:31];
                if (sq_cnt_reg == '0)
                    state_next = ST_DW_MUL;
                else
                begin
                    sq_cnt_next = sq_cnt_reg - 2'd1;
                    state_next  = ST_SQ_MUL;
                end
            end
            ST_DW_MUL: state_next = ST_DW_IDX;
            ST_DW_IDX:
            begin
                w_next     = w_reg + gwtm_pkg::W_W'(dw);
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                wi_next    = wi_reg + gwtm_pkg::WI_W'(mul_prod_reg[32+IW-1:0]);
                state_next = ST_NEXT;
            end
            ST_NEXT:
            begin
                if (gwtm_pkg::CNT_W'(idx_reg) + 1'b1 == n_bins)
                    state_next = ST_FIN;
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_RD;
                end
            end
            ST_FIN:
            begin
                if (w_reg == '0)
                begin
                    res_next.mean_halo_mass = '0;
                    res_next.invalid        = 1'b1;
                    done_next               = 1'b1;
                    state_next              = ST_IDLE;
                end
                else
                begin
                    div_n_next   = gwtm_pkg::DIV_W'(wi_reg) << 16;
                    div_d_next   = gwtm_pkg::DIV_W'(w_reg) << (gwtm_pkg::QDIV_W - 1);
                    div_q_next   = '0;
                    div_cnt_next = gwtm_pkg::DCNT_W'(gwtm_pkg::QDIV_W - 1);
                    state_next   = ST_FDIV;
                end
            end
            ST_FMUL: state_next = ST_FADD;
            ST_FADD:
            begin
                if (mean_sum[gwtm_pkg::MSUM_W-1:23] != '0
                    && mean_sum[gwtm_pkg::MSUM_W-1:23] != '1)
                    res_next.mean_halo_mass = mean_sum[gwtm_pkg::MSUM_W-1]
                                              ? 24'sh800000 : 24'sh7FFFFF;
                else
                    res_next.mean_halo_mass = mean_sum[23:0];
                res_next.invalid = 1'b0;
                done_next        = 1'b1;
                state_next       = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            div_cnt_reg   <= '0;
            k_reg         <= '0;
            sq_cnt_reg    <= '0;
            done_reg      <= 1'b0;
            cfg_start_reg <= 24'sd458752;
            cfg_step_reg  <= 16'd590;
            cfg_bins_reg  <= 11'd1000;
            cfg_obs_reg   <= 18'd0;
            cfg_int_reg   <= 18'd13107;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            div_cnt_reg   <= div_cnt_next;
            k_reg         <= k_next;
            sq_cnt_reg    <= sq_cnt_next;
            done_reg      <= done_next;
            cfg_start_reg <= cfg_start_next;
            cfg_step_reg  <= cfg_step_next;
            cfg_bins_reg  <= cfg_bins_next;
            cfg_obs_reg   <= cfg_obs_next;
            cfg_int_reg   <= cfg_int_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg        <= q_next;
        var_reg      <= var_next;
        div_n_reg    <= div_n_next;
        div_d_reg    <= div_d_next;
        div_q_reg    <= div_q_next;
        t_reg        <= t_next;
        r_reg        <= r_next;
        pd_reg       <= pd_next;
        w_reg        <= w_next;
        wi_reg       <= wi_next;
        res_reg      <= res_next;
        mul_prod_reg <= gwtm_pkg::PROD_W'(mul_a) * gwtm_pkg::PROD_W'(mul_b);
    end

    // table memories, registered read
    always_ff @(posedge clk)
    begin
        if (load_we)
        begin
            sm_mem[IW'(cmd.bin_index)]   <= cmd.bin_stellar_mass;
            dens_mem[IW'(cmd.bin_index)] <= cmd.bin_density;
        end
        sm_rd_reg   <= sm_mem[idx_reg];
        dens_rd_reg <= dens_mem[idx_reg];
    end

    `GWTM_ASSERT_IMP(a_done_after_busy, clk, rst_n, done, $past(busy))
    `GWTM_ASSERT_NXT(a_load_stays_idle, clk, rst_n,
        accept && (cmd.action == gwtm_pkg::ACT_LOAD), !busy && !done)
    `GWTM_ASSERT_NXT(a_query_goes_busy, clk, rst_n,
        accept && (cmd.action == gwtm_pkg::ACT_QUERY), busy)
    `GWTM_ASSERT_IMP(a_invalid_gives_zero, clk, rst_n,
        done && result.invalid, result.mean_halo_mass == '0)

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the gaussian weighted table mean core.
`timescale 1ns / 100ps

module tb_top;

    localparam int IDLE_LIMIT = 20000;
    localparam int FILL_BINS  = 40;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    gwtm_pkg::in_t cmd = '0;
    logic done;
    gwtm_pkg::out_t result;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [gwtm_pkg::ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    gaussian_weighted_table_mean_core i_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd(cmd),
        .done(done), .result(result), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
        .pready(pready)
    );

    always #5 clk = ~clk;

    // mirrored block state
    longint m_start;
    longint unsigned m_step, m_bins, m_obs, m_int;
    logic signed [23:0] mass_tab [gwtm_pkg::BINS];
    logic [31:0] dens_tab [gwtm_pkg::BINS];

    gwtm_pkg::in_t cmd_pending[$];
    gwtm_pkg::out_t mean_expected[$];
    int errors = 0;
    int n_loads = 0;
    int n_queries = 0;
    int n_invalid = 0;
    int idle_cycles = 0;
    logic took = 1'b0;

    function automatic longint unsigned neg_exp(longint unsigned x_q16);
        longint unsigned t, r;
        t = x_q16 << 11;
        r = 64'd1 << 31;
        for (int k = gwtm_pkg::HORNER_TERMS; k >= 1; k--)
            r = (64'd1 << 31) - (((t * r) >> 31) / 64'(k));
        for (int s = 0; s < gwtm_pkg::SQUARINGS; s++)
            r = (r * r) >> 31;
        return r;
    endfunction

    function automatic gwtm_pkg::out_t kernel_mean(logic signed [23:0] q);
        longint unsigned var_q, two_var, w, wi, dm2, x, dw, qi, rem, idx_q16;
        longint dm, mean;
        int n;
        gwtm_pkg::out_t o;
        w = 0;
        wi = 0;
        var_q = m_obs * m_obs + m_int * m_int;
        two_var = 2 * var_q;
        n = (m_bins > 64'(gwtm_pkg::BINS)) ? gwtm_pkg::BINS : int'(m_bins);
        o = '0;
        if (var_q != 0) begin
            for (int i = 0; i < n; i++) begin
                dm = longint'(q) - longint'(mass_tab[gwtm_pkg::IDX_W'(i)]);
                dm2 = 64'(dm * dm);
                if (dm2 < 16 * two_var) begin
                    x = (dm2 << 16) / two_var;
                    dw = (64'(dens_tab[gwtm_pkg::IDX_W'(i)]) * neg_exp(x)) >> 31;
                    w += dw;
                    wi += dw * 64'(i);
                end
            end
        end
        if (var_q == 0 || w == 0) begin
            o.invalid = 1'b1;
            return o;
        end
        qi = wi / w;
        rem = wi % w;
        idx_q16 = (qi << 16) + ((rem << 16) / w);
        mean = m_start + longint'((idx_q16 * m_step) >> 16);
        if (mean > 8388607)
            mean = 8388607;
        if (mean < -8388608)
            mean = -8388608;
        o.mean_halo_mass = mean[23:0];
        return o;
    endfunction

    // monitor: input transfers, register writes, results
    always @(posedge clk)
    begin
        gwtm_pkg::out_t exp_o;
        logic act;
        act = 1'b0;
        took <= start && !busy && rst_n;
        if (rst_n) begin
            if (psel && penable && pwrite && pready) begin
                act = 1'b1;
                case (paddr[gwtm_pkg::ADDR_W-1:2])
                    gwtm_pkg::REG_GRID_START:  m_start = longint'(signed'(pwdata[23:0]));
                    gwtm_pkg::REG_GRID_STEP:   m_step = 64'(pwdata[15:0]);
                    gwtm_pkg::REG_BINS_IN_USE: m_bins = 64'(pwdata[10:0]);
                    gwtm_pkg::REG_OBS_SCATTER: m_obs = 64'(pwdata[17:0]);
                    gwtm_pkg::REG_INT_SCATTER: m_int = 64'(pwdata[17:0]);
                    default: ;
                endcase
            end
            if (done) begin
                act = 1'b1;
                if (mean_expected.size() == 0) begin
                    $display("%0t: result with none pending: exp none act %h/%b", $time,
                        result.mean_halo_mass, result.invalid);
                    errors++;
                end else begin
                    exp_o = mean_expected.pop_front();
                    if (result.mean_halo_mass !== exp_o.mean_halo_mass)
                    begin
                        $display("%0t: mean_halo_mass exp %h act %h", $time,
                            exp_o.mean_halo_mass, result.mean_halo_mass);
                        errors++;
                    end
                    if (result.invalid !== exp_o.invalid)
                    begin
                        $display("%0t: invalid exp %b act %b", $time,
                            exp_o.invalid, result.invalid);
                        errors++;
                    end
                    if (exp_o.invalid)
                        n_invalid++;
                end
            end
            if (start && !busy) begin
                act = 1'b1;
                if (cmd.action == gwtm_pkg::ACT_LOAD) begin
                    mass_tab[cmd.bin_index] = cmd.bin_stellar_mass;
                    dens_tab[cmd.bin_index] = cmd.bin_density;
                    n_loads++;
                end else begin
                    mean_expected.push_back(kernel_mean(cmd.query_mass));
                    n_queries++;
                end
            end
            idle_cycles = act ? 0 : idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    // driver: bursts of transfers separated by random gaps
    int burst_left = 0;
    int gap_left = 0;
    always @(negedge clk)
    begin
        logic nxt_start;
        gwtm_pkg::in_t nxt_cmd;
        nxt_start = start;
        nxt_cmd = cmd;
        if (rst_n && !(start && !took)) begin
            nxt_start = 1'b0;
            if (gap_left > 0)
                gap_left--;
            else if (cmd_pending.size() > 0) begin
                nxt_cmd = cmd_pending.pop_front();
                nxt_start = 1'b1;
                if (burst_left > 0)
                    burst_left--;
                else begin
                    burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(20, 60)
                                                            : $urandom_range(0, 6);
                    gap_left = $urandom_range(0, 1) ? 0 : $urandom_range(1, 5);
                end
            end
        end
        start <= nxt_start;
        cmd <= nxt_cmd;
    end

    task automatic reg_write(gwtm_pkg::reg_addr_t r, logic [31:0] v);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {r, 2'b00};
        pwdata <= v;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_cfg(logic [23:0] gs, logic [15:0] st, logic [10:0] nb,
                           logic [17:0] ob, logic [17:0] it);
        reg_write(gwtm_pkg::REG_GRID_START, {8'd0, gs});
        reg_write(gwtm_pkg::REG_GRID_STEP, {16'd0, st});
        reg_write(gwtm_pkg::REG_BINS_IN_USE, {21'd0, nb});
        reg_write(gwtm_pkg::REG_OBS_SCATTER, {14'd0, ob});
        reg_write(gwtm_pkg::REG_INT_SCATTER, {14'd0, it});
    endtask

    task automatic drain();
        while (cmd_pending.size() != 0 || start || mean_expected.size() != 0 || busy)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    function automatic gwtm_pkg::in_t load_item(logic [9:0] idx, logic [23:0] m,
                                                logic [31:0] d);
        gwtm_pkg::in_t c;
        c = gwtm_pkg::in_t'($bits(gwtm_pkg::in_t)'({$urandom(), $urandom(), $urandom()}));
        c.action = gwtm_pkg::ACT_LOAD;
        c.bin_index = idx;
        c.bin_stellar_mass = m;
        c.bin_density = d;
        return c;
    endfunction

    function automatic gwtm_pkg::in_t query_item(logic [23:0] q);
        gwtm_pkg::in_t c;
        c = gwtm_pkg::in_t'($bits(gwtm_pkg::in_t)'({$urandom(), $urandom(), $urandom()}));
        c.action = gwtm_pkg::ACT_QUERY;
        c.query_mass = q;
        return c;
    endfunction

    initial
    begin
        int center, nb;
        m_start = 458752;
        m_step = 590;
        m_bins = 1000;
        m_obs = 0;
        m_int = 13107;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        // walk only the bins filled below so no query reads an unwritten entry
        set_cfg(24'd458752, 16'd590, 11'(FILL_BINS), 18'd0, 18'd13107);
        for (int i = 0; i < FILL_BINS; i++)
            cmd_pending.push_back(load_item(10'(i), 24'($urandom()), $urandom()));
        cmd_pending.push_back(load_item(10'd5, 24'h000000, 32'hFFFF_FFFF));
        cmd_pending.push_back(load_item(10'd6, 24'h7FFFFF, 32'h0000_0001));
        cmd_pending.push_back(load_item(10'd7, 24'h800000, 32'hFFFF_FFFF));
        cmd_pending.push_back(query_item(24'h000000));
        cmd_pending.push_back(query_item(24'h7FFFFF));
        cmd_pending.push_back(query_item(24'h800000));
        drain();

        // tiny variance, widest grid
        set_cfg(24'h800000, 16'hFFFF, 11'(FILL_BINS), 18'd0, 18'd1);
        cmd_pending.push_back(query_item(24'h7FFFFF));
        cmd_pending.push_back(query_item(24'h800000));
        cmd_pending.push_back(query_item(mass_tab[30]));
        drain();

        // zero variance
        set_cfg(24'd0, 16'd590, 11'd8, 18'd0, 18'd0);
        cmd_pending.push_back(query_item(mass_tab[0]));
        cmd_pending.push_back(query_item(24'h123456));
        drain();

        // no bins walked
        set_cfg(24'd458752, 16'd590, 11'd0, 18'd3000, 18'd13107);
        cmd_pending.push_back(query_item(mass_tab[0]));
        drain();

        // widest kernel, high saturation; zero density gives zero weight
        set_cfg(24'h7FFFFF, 16'hFFFF, 11'd16, 18'h3FFFF, 18'h3FFFF);
        for (int i = 0; i < 16; i++)
            cmd_pending.push_back(load_item(10'(i), 24'($urandom_range(0, 65535)), 32'd0));
        cmd_pending.push_back(query_item(24'd100));
        cmd_pending.push_back(load_item(10'd15, 24'd0, 32'hFFFF_FFFF));
        cmd_pending.push_back(query_item(24'd100));
        drain();

        for (int ph = 0; ph < 9; ph++) begin
            nb = ($urandom_range(0, 5) == 0) ? $urandom_range(17, FILL_BINS)
                                             : $urandom_range(1, 16);
            set_cfg(24'($urandom()), 16'($urandom()), 11'(nb),
                    $urandom_range(0, 3) == 0 ? 18'($urandom_range(0, 262143))
                                              : 18'($urandom_range(0, 20000)),
                    $urandom_range(0, 3) == 0 ? 18'($urandom_range(0, 262143))
                                              : 18'($urandom_range(1, 20000)));
            center = $urandom_range(0, 16777215) - 8388608;
            for (int k = 0; k < 56; k++) begin
                case ($urandom_range(0, 9))
                    0: cmd_pending.push_back(load_item(10'($urandom()), 24'($urandom()),
                        $urandom()));
                    1, 2, 3, 4: cmd_pending.push_back(load_item(10'($urandom_range(0, nb - 1)),
                        24'(center + $urandom_range(0, 131072) - 65536),
                        $urandom_range(0, 7) == 0 ? 32'd0 : $urandom()));
                    5: cmd_pending.push_back(query_item(24'($urandom())));
                    default: cmd_pending.push_back(query_item(
                        24'(center + $urandom_range(0, 131072) - 65536)));
                endcase
            end
            drain();
        end

        $display("Covered %0d bin loads and %0d queries (%0d flagged invalid)",
            n_loads, n_queries, n_invalid);
        $display("over directed corner settings and 9 random register settings.");
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
